FILE: sv/aes128_pkg.sv
// Package: AES-128 types, S-box, GF(2^8) helpers and round functions
`default_nettype none
package aes128_pkg;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned CfgIdxW   = 1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KEY_HIGH = 1'b0,
    REG_KEY_LOW  = 1'b1
  } cfg_reg_t;

  typedef logic [127:0] block_t;
  typedef logic [7:0]   rcon_t;

  // Data and key travelling together between round cells
  typedef struct packed {
    logic   vld;
    block_t state;
    block_t rkey;
    rcon_t  rcon;
  } cell_bus_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] r;
    unique case (a)
      8'h00: r=8'h63; 8'h01: r=8'h7C; 8'h02: r=8'h77; 8'h03: r=8'h7B;
      8'h04: r=8'hF2; 8'h05: r=8'h6B; 8'h06: r=8'h6F; 8'h07: r=8'hC5;
      8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0A: r=8'h67; 8'h0B: r=8'h2B;
      8'h0C: r=8'hFE; 8'h0D: r=8'hD7; 8'h0E: r=8'hAB; 8'h0F: r=8'h76;
      8'h10: r=8'hCA; 8'h11: r=8'h82; 8'h12: r=8'hC9; 8'h13: r=8'h7D;
      8'h14: r=8'hFA; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hF0;
      8'h18: r=8'hAD; 8'h19: r=8'hD4; 8'h1A: r=8'hA2; 8'h1B: r=8'hAF;
      8'h1C: r=8'h9C; 8'h1D: r=8'hA4; 8'h1E: r=8'h72; 8'h1F: r=8'hC0;
      8'h20: r=8'hB7; 8'h21: r=8'hFD; 8'h22: r=8'h93; 8'h23: r=8'h26;
      8'h24: r=8'h36; 8'h25: r=8'h3F; 8'h26: r=8'hF7; 8'h27: r=8'hCC;
      8'h28: r=8'h34; 8'h29: r=8'hA5; 8'h2A: r=8'hE5; 8'h2B: r=8'hF1;
      8'h2C: r=8'h71; 8'h2D: r=8'hD8; 8'h2E: r=8'h31; 8'h2F: r=8'h15;
      8'h30: r=8'h04; 8'h31: r=8'hC7; 8'h32: r=8'h23; 8'h33: r=8'hC3;
      8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9A;
      8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3A: r=8'h80; 8'h3B: r=8'hE2;
      8'h3C: r=8'hEB; 8'h3D: r=8'h27; 8'h3E: r=8'hB2; 8'h3F: r=8'h75;
      8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2C; 8'h43: r=8'h1A;
      8'h44: r=8'h1B; 8'h45: r=8'h6E; 8'h46: r=8'h5A; 8'h47: r=8'hA0;
      8'h48: r=8'h52; 8'h49: r=8'h3B; 8'h4A: r=8'hD6; 8'h4B: r=8'hB3;
      8'h4C: r=8'h29; 8'h4D: r=8'hE3; 8'h4E: r=8'h2F; 8'h4F: r=8'h84;
      8'h50: r=8'h53; 8'h51: r=8'hD1; 8'h52: r=8'h00; 8'h53: r=8'hED;
      8'h54: r=8'h20; 8'h55: r=8'hFC; 8'h56: r=8'hB1; 8'h57: r=8'h5B;
      8'h58: r=8'h6A; 8'h59: r=8'hCB; 8'h5A: r=8'hBE; 8'h5B: r=8'h39;
      8'h5C: r=8'h4A; 8'h5D: r=8'h4C; 8'h5E: r=8'h58; 8'h5F: r=8'hCF;
      8'h60: r=8'hD0; 8'h61: r=8'hEF; 8'h62: r=8'hAA; 8'h63: r=8'hFB;
      8'h64: r=8'h43; 8'h65: r=8'h4D; 8'h66: r=8'h33; 8'h67: r=8'h85;
      8'h68: r=8'h45; 8'h69: r=8'hF9; 8'h6A: r=8'h02; 8'h6B: r=8'h7F;
      8'h6C: r=8'h50; 8'h6D: r=8'h3C; 8'h6E: r=8'h9F; 8'h6F: r=8'hA8;
      8'h70: r=8'h51; 8'h71: r=8'hA3; 8'h72: r=8'h40; 8'h73: r=8'h8F;
      8'h74: r=8'h92; 8'h75: r=8'h9D; 8'h76: r=8'h38; 8'h77: r=8'hF5;
      8'h78: r=8'hBC; 8'h79: r=8'hB6; 8'h7A: r=8'hDA; 8'h7B: r=8'h21;
      8'h7C: r=8'h10; 8'h7D: r=8'hFF; 8'h7E: r=8'hF3; 8'h7F: r=8'hD2;
      8'h80: r=8'hCD; 8'h81: r=8'h0C; 8'h82: r=8'h13; 8'h83: r=8'hEC;
      8'h84: r=8'h5F; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
      8'h88: r=8'hC4; 8'h89: r=8'hA7; 8'h8A: r=8'h7E; 8'h8B: r=8'h3D;
      8'h8C: r=8'h64; 8'h8D: r=8'h5D; 8'h8E: r=8'h19; 8'h8F: r=8'h73;
      8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4F; 8'h93: r=8'hDC;
      8'h94: r=8'h22; 8'h95: r=8'h2A; 8'h96: r=8'h90; 8'h97: r=8'h88;
      8'h98: r=8'h46; 8'h99: r=8'hEE; 8'h9A: r=8'hB8; 8'h9B: r=8'h14;
      8'h9C: r=8'hDE; 8'h9D: r=8'h5E; 8'h9E: r=8'h0B; 8'h9F: r=8'hDB;
      8'hA0: r=8'hE0; 8'hA1: r=8'h32; 8'hA2: r=8'h3A; 8'hA3: r=8'h0A;
      8'hA4: r=8'h49; 8'hA5: r=8'h06; 8'hA6: r=8'h24; 8'hA7: r=8'h5C;
      8'hA8: r=8'hC2; 8'hA9: r=8'hD3; 8'hAA: r=8'hAC; 8'hAB: r=8'h62;
      8'hAC: r=8'h91; 8'hAD: r=8'h95; 8'hAE: r=8'hE4; 8'hAF: r=8'h79;
      8'hB0: r=8'hE7; 8'hB1: r=8'hC8; 8'hB2: r=8'h37; 8'hB3: r=8'h6D;
      8'hB4: r=8'h8D; 8'hB5: r=8'hD5; 8'hB6: r=8'h4E; 8'hB7: r=8'hA9;
      8'hB8: r=8'h6C; 8'hB9: r=8'h56; 8'hBA: r=8'hF4; 8'hBB: r=8'hEA;
      8'hBC: r=8'h65; 8'hBD: r=8'h7A; 8'hBE: r=8'hAE; 8'hBF: r=8'h08;
      8'hC0: r=8'hBA; 8'hC1: r=8'h78; 8'hC2: r=8'h25; 8'hC3: r=8'h2E;
      8'hC4: r=8'h1C; 8'hC5: r=8'hA6; 8'hC6: r=8'hB4; 8'hC7: r=8'hC6;
      8'hC8: r=8'hE8; 8'hC9: r=8'hDD; 8'hCA: r=8'h74; 8'hCB: r=8'h1F;
      8'hCC: r=8'h4B; 8'hCD: r=8'hBD; 8'hCE: r=8'h8B; 8'hCF: r=8'h8A;
      8'hD0: r=8'h70; 8'hD1: r=8'h3E; 8'hD2: r=8'hB5; 8'hD3: r=8'h66;
      8'hD4: r=8'h48; 8'hD5: r=8'h03; 8'hD6: r=8'hF6; 8'hD7: r=8'h0E;
      8'hD8: r=8'h61; 8'hD9: r=8'h35; 8'hDA: r=8'h57; 8'hDB: r=8'hB9;
      8'hDC: r=8'h86; 8'hDD: r=8'hC1; 8'hDE: r=8'h1D; 8'hDF: r=8'h9E;
      8'hE0: r=8'hE1; 8'hE1: r=8'hF8; 8'hE2: r=8'h98; 8'hE3: r=8'h11;
      8'hE4: r=8'h69; 8'hE5: r=8'hD9; 8'hE6: r=8'h8E; 8'hE7: r=8'h94;
      8'hE8: r=8'h9B; 8'hE9: r=8'h1E; 8'hEA: r=8'h87; 8'hEB: r=8'hE9;
      8'hEC: r=8'hCE; 8'hED: r=8'h55; 8'hEE: r=8'h28; 8'hEF: r=8'hDF;
      8'hF0: r=8'h8C; 8'hF1: r=8'hA1; 8'hF2: r=8'h89; 8'hF3: r=8'h0D;
      8'hF4: r=8'hBF; 8'hF5: r=8'hE6; 8'hF6: r=8'h42; 8'hF7: r=8'h68;
      8'hF8: r=8'h41; 8'hF9: r=8'h99; 8'hFA: r=8'h2D; 8'hFB: r=8'h0F;
      8'hFC: r=8'hB0; 8'hFD: r=8'h54; 8'hFE: r=8'hBB; 8'hFF: r=8'h16;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1B : 8'h00);
  endfunction

  // Byte i of the block sits at bits [127-8i -: 8]
  function automatic logic [7:0] get_byte(input block_t s, input int unsigned i);
    return s[127-8*i -: 8];
  endfunction

  function automatic block_t sub_shift(input block_t s);
    block_t t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127-8*(4*c+r) -: 8] = sbox(get_byte(s, 4*((c+r)%4)+r));
      end
    end
    return t;
  endfunction

  function automatic block_t mix_cols(input block_t s);
    block_t t;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(s, 4*c);
      a1 = get_byte(s, 4*c+1);
      a2 = get_byte(s, 4*c+2);
      a3 = get_byte(s, 4*c+3);
      t[127-32*c -: 8]   = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
      t[119-32*c -: 8]   = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
      t[111-32*c -: 8]   = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
      t[103-32*c -: 8]   = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
    end
    return t;
  endfunction

  function automatic block_t next_key(input block_t k, input rcon_t rc);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96];
    w1 = k[95:64];
    w2 = k[63:32];
    w3 = k[31:0];
    t = {sbox(w3[23:16]), sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])}
        ^ {rc, 24'h0};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

endpackage
`default_nettype wire

FILE: sv/aes128_round_cell.sv
// Round cell: one AES round and the matching key expansion step, registered
`default_nettype none
module aes128_round_cell (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   en,
  input  wire logic                   last_round,
  input  wire aes128_pkg::cell_bus_t  bus_in,
  output aes128_pkg::cell_bus_t       bus_out
);

  aes128_pkg::cell_bus_t bus_r, bus_nxt;
  aes128_pkg::block_t    key_nxt, ss;

  always_comb begin
    key_nxt = aes128_pkg::next_key(bus_in.rkey, bus_in.rcon);
    ss      = aes128_pkg::sub_shift(bus_in.state);
    bus_nxt.vld   = bus_in.vld;
    bus_nxt.rkey  = key_nxt;
    bus_nxt.rcon  = aes128_pkg::xtime(bus_in.rcon);
    // skip MixColumns in the final round
    bus_nxt.state = (last_round ? ss : aes128_pkg::mix_cols(ss)) ^ key_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bus_r.vld <= 1'b0;
    end else if (en) begin
      bus_r.vld <= bus_nxt.vld;
    end
    if (en) begin
      bus_r.state <= bus_nxt.state;
      bus_r.rkey  <= bus_nxt.rkey;
      bus_r.rcon  <= bus_nxt.rcon;
    end
  end

  assign bus_out = bus_r;

endmodule
`default_nettype wire

FILE: sv/aes128_block_encrypt_unit.sv
// AES-128 encryption top level: key registers, whitening stage and chain of round cells
//
// Usage:
//   Write the key through cfg_*: index 0 = key bytes 0..7, index 1 = bytes 8..15.
//   Keys are taken into the pipeline with each item, so rewrite only when idle.
//   in_tdata carries one plaintext block, out_tdata one ciphertext block.
//   Pipeline: whitening stage plus ten round cells, each a register stage
//   carrying state and round key.
//   Throughput: one item per cycle while the output is not stalled; the whole chain advances as one.
//   Stall: when out_tvalid is high and out_tready low the chain holds, and
//   in_tready drops; the chain advances whenever the output stage is empty
//   or read, and empty stages inside the chain move along with it.
//   Reset (rst_n low, synchronous): key registers clear to zero and all
//   stage valid bits clear; no item is in flight afterwards.
//   Every item gives exactly one result, in order.
`default_nettype none
module aes128_block_encrypt_unit (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [127:0] in_tdata,   // [63:0] plain_high, [127:64] plain_low
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [127:0]      out_tdata,  // [63:0] cipher_high, [127:64] cipher_low
  input  wire logic         cfg_we,
  input  wire logic [aes128_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [63:0]  cfg_wdata
);

  localparam int unsigned NR = aes128_pkg::NumRounds;

  logic [63:0] key_high_r, key_low_r;
  aes128_pkg::cell_bus_t stage_r;
  aes128_pkg::cell_bus_t chain [NR+1];
  logic adv;
  logic [NR:0] vlds;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
    end else if (cfg_we) begin
      unique case (aes128_pkg::cfg_reg_t'(cfg_index))
        aes128_pkg::REG_KEY_HIGH: key_high_r <= cfg_wdata;
        aes128_pkg::REG_KEY_LOW:  key_low_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // advance the whole chain unless the output stage is full and stalled
  assign adv       = !chain[NR].vld || out_tready;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.vld <= 1'b0;
    end else if (adv) begin
      stage_r.vld <= in_tvalid;
    end
    if (adv) begin
      stage_r.state <= {in_tdata[63:0], in_tdata[127:64]} ^ {key_high_r, key_low_r};
      stage_r.rkey  <= {key_high_r, key_low_r};
      stage_r.rcon  <= 8'h01;
    end
  end

  assign chain[0] = stage_r;

  for (genvar g = 0; g < NR; g++) begin : g_round
    aes128_round_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .en         (adv),
      .last_round (g == NR-1),
      .bus_in     (chain[g]),
      .bus_out    (chain[g+1])
    );
  end

  for (genvar v = 0; v <= NR; v++) begin : g_vld
    assign vlds[v] = chain[v].vld;
  end

  assign out_tvalid = chain[NR].vld;
  assign out_tdata  = {chain[NR].state[63:0], chain[NR].state[127:64]};

`ifndef SYNTHESIS
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output stage");
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> chain[0].vld)
    else $error("accepted item lost at entry");
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> vlds == '0)
    else $error("chain not empty after reset");
`endif

endmodule
`default_nettype wire

FILE: test/aes128_block_encrypt_unit_tb.sv
// Testbench: AES-128 block encryption unit, checked against an in-bench cipher model
`default_nettype none
module aes128_block_encrypt_unit_tb;

  typedef struct {
    logic [63:0] ph;
    logic [63:0] pl;
    logic        known;
    logic [63:0] ch;
    logic [63:0] cl;
  } vec_t;

  typedef struct {
    logic [63:0] hi;
    logic [63:0] lo;
  } cblk_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;
  logic         cfg_we = 1'b0;
  logic         cfg_index = 1'b0;
  logic [63:0]  cfg_wdata = '0;

  logic [7:0]  subst [256];
  logic [63:0] key_hi_m, key_lo_m;
  cblk_t       cipher_q [$];
  vec_t        vectors [$];
  int          errors = 0;
  int          cycles = 0;
  bit          calm = 1'b0;
  bit          long_stall = 1'b0;
  bit          stall_done = 1'b0;
  int          hold_off = 0;

  aes128_block_encrypt_unit u_top (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .cfg_we, .cfg_index, .cfg_wdata
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Build the S-box from the field inverse and the affine map
  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return p;
  endfunction

  function automatic logic [7:0] dbl(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic cblk_t encrypt_block(input logic [63:0] ph, input logic [63:0] pl);
    logic [31:0] w [44];
    logic [7:0]  s [16];
    logic [7:0]  t [16];
    logic [31:0] tmp;
    logic [7:0]  rc, a0, a1, a2, a3;
    cblk_t       r;
    rc = 8'h01;
    w[0] = key_hi_m[63:32]; w[1] = key_hi_m[31:0];
    w[2] = key_lo_m[63:32]; w[3] = key_lo_m[31:0];
    for (int i = 4; i < 44; i++) begin
      tmp = w[i-1];
      if (i % 4 == 0) begin
        tmp = {subst[tmp[23:16]], subst[tmp[15:8]], subst[tmp[7:0]], subst[tmp[31:24]]}
              ^ {rc, 24'h0};
        rc = dbl(rc);
      end
      w[i] = w[i-4] ^ tmp;
    end
    for (int i = 0; i < 8; i++) begin
      s[i] = ph[63-8*i -: 8];
      s[8+i] = pl[63-8*i -: 8];
    end
    for (int rnd = 0; rnd <= 10; rnd++) begin
      if (rnd > 0) begin
        for (int c = 0; c < 4; c++)
          for (int q = 0; q < 4; q++) t[4*c+q] = subst[s[4*((c+q)%4)+q]];
        for (int c = 0; c < 4; c++) begin
          a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
          if (rnd < 10) begin
            t[4*c]   = dbl(a0) ^ dbl(a1) ^ a1 ^ a2 ^ a3;
            t[4*c+1] = a0 ^ dbl(a1) ^ dbl(a2) ^ a2 ^ a3;
            t[4*c+2] = a0 ^ a1 ^ dbl(a2) ^ dbl(a3) ^ a3;
            t[4*c+3] = dbl(a0) ^ a0 ^ a1 ^ a2 ^ dbl(a3);
          end
        end
        s = t;
      end
      for (int c = 0; c < 4; c++)
        for (int q = 0; q < 4; q++) s[4*c+q] ^= w[4*rnd+c][31-8*q -: 8];
    end
    for (int i = 0; i < 8; i++) begin
      r.hi[63-8*i -: 8] = s[i];
      r.lo[63-8*i -: 8] = s[8+i];
    end
    return r;
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  task automatic write_key(input aes128_pkg::cfg_reg_t idx, input logic [63:0] val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == aes128_pkg::REG_KEY_HIGH) key_hi_m = val; else key_lo_m = val;
  endtask

  // Valid stays high after an accept; the next idle cycle or drain drops it
  task automatic send_block(input logic [63:0] ph, input logic [63:0] pl);
    while (!calm && $urandom_range(99) < 15) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {pl, ph};
    cipher_q.push_back(encrypt_block(ph, pl));
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    while (cipher_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_tready <= 1'b0;
    end else if (long_stall && !stall_done) begin
      hold_off <= 300;
      stall_done <= 1'b1;
      out_tready <= 1'b0;
    end else out_tready <= calm || ($urandom_range(99) >= 15);
  end

  always @(posedge clk) begin
    cblk_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (cipher_q.size() == 0) begin
        report("unexpected result", out_tdata[63:0], '0);
      end else begin
        e = cipher_q.pop_front();
        if (out_tdata[63:0] !== e.hi) report("cipher_high", out_tdata[63:0], e.hi);
        if (out_tdata[127:64] !== e.lo) report("cipher_low", out_tdata[127:64], e.lo);
      end
    end
  end

  function automatic logic [63:0] rand64;
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  initial begin
    logic [7:0] inv, b;
    vec_t v;
    cblk_t got;
    for (int x = 0; x < 256; x++) begin
      inv = 8'h00;
      for (int y = 1; y < 256; y++) if (gmul(x[7:0], y[7:0]) == 8'h01) inv = y[7:0];
      b = inv;
      subst[x] = b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]}
                 ^ {b[3:0], b[7:4]} ^ 8'h63;
    end
    key_hi_m = '0; key_lo_m = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Zero key after reset: well-known result typed in for the all-zero block; others from the model
    vectors.push_back('{64'h0, 64'h0, 1'b1, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e});
    vectors.push_back('{'1, '1, 1'b0, '0, '0});
    vectors.push_back('{64'h8000000000000000, 64'h0, 1'b0, '0, '0});
    vectors.push_back('{64'h0, 64'h1, 1'b0, '0, '0});
    vectors.push_back('{64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 1'b0, '0, '0});
    foreach (vectors[i]) begin
      v = vectors[i];
      if (v.known) begin
        got = encrypt_block(v.ph, v.pl);
        if (got.hi !== v.ch) report("model zero-key high", got.hi, v.ch);
        if (got.lo !== v.cl) report("model zero-key low", got.lo, v.cl);
      end
      send_block(v.ph, v.pl);
    end
    drain();

    // FIPS-197 example key and block
    write_key(aes128_pkg::REG_KEY_LOW, 64'h08090a0b0c0d0e0f);
    write_key(aes128_pkg::REG_KEY_HIGH, 64'h0001020304050607);
    got = encrypt_block(64'h0011223344556677, 64'h8899aabbccddeeff);
    if (got.hi !== 64'h69c4e0d86a7b0430) report("model fips high", got.hi, 64'h69c4e0d86a7b0430);
    if (got.lo !== 64'hd8cdb78070b4c55a) report("model fips low", got.lo, 64'hd8cdb78070b4c55a);
    send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
    send_block('1, '0);
    drain();

    write_key(aes128_pkg::REG_KEY_HIGH, '1);
    write_key(aes128_pkg::REG_KEY_LOW, '1);
    repeat (8) send_block(rand64(), rand64());
    drain();

    // Random phases under varied keys; one phase without idling, one with a long stall
    for (int ph = 0; ph < 8; ph++) begin
      write_key(aes128_pkg::REG_KEY_HIGH, rand64());
      write_key(aes128_pkg::REG_KEY_LOW, rand64());
      calm = (ph == 2);
      long_stall = (ph == 4);
      repeat (200) send_block(rand64(), rand64());
      drain();
    end
    calm = 1'b0;

    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule
`default_nettype wire
